// ===== src/brca_pkg.sv =====
// Shared types, codes and the CRC byte update for the block receive core.
package brca_pkg;

    // Longest file name, in nonzero bytes, before lengths are expected
    localparam int NAME_MAX_BYTES = 512;
    localparam int NAME_CNT_W     = 10;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRC_SEED      = 3'd0,
        REG_CRC_FINAL_XOR = 3'd1,
        REG_ACK_CODE      = 3'd2,
        REG_NAK_CODE      = 3'd3,
        REG_START_COMMAND = 3'd4
    } cfg_reg_t;

    localparam logic [15:0] CRC_SEED_RST      = 16'hFFFF;
    localparam logic [15:0] CRC_FINAL_XOR_RST = 16'h0000;
    localparam logic [7:0]  ACK_CODE_RST      = 8'h06;
    localparam logic [7:0]  NAK_CODE_RST      = 8'h15;
    localparam logic [7:0]  START_COMMAND_RST = 8'h02;

    typedef struct packed {
        logic [15:0] crc_seed;
        logic [15:0] crc_final_xor;
        logic [7:0]  ack_code;
        logic [7:0]  nak_code;
        logic [7:0]  start_command;
    } cfg_t;

    // Receive phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_NAME   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC_HI = 3'd5,
        PH_CRC_LO = 3'd6
    } phase_t;

    // Output codes
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    localparam logic [1:0] PAY_NONE = 2'd0;
    localparam logic [1:0] PAY_NAME = 2'd1;
    localparam logic [1:0] PAY_DATA = 2'd2;

    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_GOOD     = 2'd1;
    localparam logic [1:0] STAT_BAD      = 2'd2;
    localparam logic [1:0] STAT_FILE_END = 2'd3;

    // One result item
    typedef struct packed {
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic [15:0] block_length;
        logic [7:0]  retry_number;
        logic [15:0] block_number;
        logic [1:0]  block_status;
        logic [7:0]  payload_byte;
        logic [1:0]  payload_kind;
        logic [1:0]  reply_kind;
    } res_t;

    localparam int TDATA_W = 88;

    // CRC-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/brca_cfg.sv =====
// Configuration register file for the block receive core.
module brca_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brca_pkg::CFG_DATA_W-1:0]   cfg_data,
    output brca_pkg::cfg_t                    cfg
);
    import brca_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CRC_SEED:      cfg_next.crc_seed      = cfg_data;
                REG_CRC_FINAL_XOR: cfg_next.crc_final_xor = cfg_data;
                REG_ACK_CODE:      cfg_next.ack_code      = cfg_data[7:0];
                REG_NAK_CODE:      cfg_next.nak_code      = cfg_data[7:0];
                REG_START_COMMAND: cfg_next.start_command = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_seed      <= CRC_SEED_RST;
            cfg_reg.crc_final_xor <= CRC_FINAL_XOR_RST;
            cfg_reg.ack_code      <= ACK_CODE_RST;
            cfg_reg.nak_code      <= NAK_CODE_RST;
            cfg_reg.start_command <= START_COMMAND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/brca_fsm.sv =====
// Receive protocol state and per-byte result logic.
module brca_fsm (
    input  logic           aclk,
    input  logic           aresetn,
    input  brca_pkg::cfg_t cfg,
    input  logic           in_take,
    input  logic [7:0]     rx_byte,
    output brca_pkg::res_t res
);
    import brca_pkg::*;

    phase_t                phase_reg,     phase_next;
    logic [15:0]           crc_reg,       crc_next;
    logic [15:0]           bytes_seen_reg, bytes_seen_next;
    logic [15:0]           length_reg,    length_next;
    logic [7:0]            high_hold_reg, high_hold_next;
    logic [NAME_CNT_W-1:0] name_cnt_reg,  name_cnt_next;
    logic [15:0]           block_cnt_reg, block_cnt_next;
    logic [7:0]            retry_cnt_reg, retry_cnt_next;

    logic                  name_full;
    logic [15:0]           len_word;
    logic [15:0]           crc_word;
    logic [15:0]           crc_final;
    logic [15:0]           seen_inc;

    assign name_full = ({1'b0, name_cnt_reg} + {{NAME_CNT_W{1'b0}}, 1'b1})
                       >= (NAME_CNT_W+1)'(NAME_MAX_BYTES);
    assign len_word  = {high_hold_reg, rx_byte};
    assign crc_word  = {high_hold_reg, rx_byte};
    assign crc_final = crc_reg ^ cfg.crc_final_xor;
    assign seen_inc  = bytes_seen_reg + 16'd1;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:   if (rx_byte == cfg.start_command) phase_next = PH_NAME;
            PH_NAME:   if (rx_byte == 8'd0 || name_full) phase_next = PH_LEN_HI;
            PH_LEN_HI: phase_next = PH_LEN_LO;
            PH_LEN_LO: phase_next = (len_word == 16'd0) ? PH_IDLE : PH_DATA;
            PH_DATA:   if (seen_inc >= length_reg) phase_next = PH_CRC_HI;
            PH_CRC_HI: phase_next = PH_CRC_LO;
            PH_CRC_LO: phase_next = PH_LEN_HI;
            default:   phase_next = PH_IDLE;
        endcase
    end

    // Counters, holds and the result item
    always_comb begin
        crc_next        = crc_reg;
        bytes_seen_next = bytes_seen_reg;
        length_next     = length_reg;
        high_hold_next  = high_hold_reg;
        name_cnt_next   = name_cnt_reg;
        block_cnt_next  = block_cnt_reg;
        retry_cnt_next  = retry_cnt_reg;
        res             = '0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == cfg.start_command) begin
                    res.reply_kind = REPLY_ACK;
                    name_cnt_next  = '0;
                    block_cnt_next = '0;
                    retry_cnt_next = '0;
                    length_next    = '0;
                end
            end
            PH_NAME: begin
                res.reply_kind = REPLY_ACK;
                if (rx_byte != 8'd0) begin
                    res.payload_kind = PAY_NAME;
                    res.payload_byte = rx_byte;
                    name_cnt_next    = name_full ? '0 : name_cnt_reg + 1'b1;
                end
            end
            PH_LEN_HI: begin
                res.reply_kind = REPLY_ACK;
                high_hold_next = rx_byte;
            end
            PH_LEN_LO: begin
                res.reply_kind = REPLY_ACK;
                length_next    = len_word;
                if (len_word == 16'd0) begin
                    res.block_status = STAT_FILE_END;
                end else begin
                    if (retry_cnt_reg == 8'd0) block_cnt_next = block_cnt_reg + 16'd1;
                    crc_next        = cfg.crc_seed;
                    bytes_seen_next = '0;
                end
            end
            PH_DATA: begin
                res.reply_kind   = REPLY_ACK;
                res.payload_kind = PAY_DATA;
                res.payload_byte = rx_byte;
                crc_next         = crc_byte(crc_reg, rx_byte);
                bytes_seen_next  = seen_inc;
            end
            PH_CRC_HI: begin
                res.reply_kind = REPLY_ACK;
                high_hold_next = rx_byte;
            end
            PH_CRC_LO: begin
                res.received_crc = crc_word;
                res.computed_crc = crc_final;
                if (crc_word == crc_final) begin
                    res.reply_kind   = REPLY_ACK;
                    res.block_status = STAT_GOOD;
                    retry_cnt_next   = '0;
                end else begin
                    res.reply_kind   = REPLY_NAK;
                    res.block_status = STAT_BAD;
                    if (retry_cnt_reg != 8'hFF) retry_cnt_next = retry_cnt_reg + 8'd1;
                end
            end
            default: ;
        endcase
        res.block_number = block_cnt_next;
        res.retry_number = retry_cnt_next;
        res.block_length = length_next;
    end

    // Advance state on each taken item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            crc_reg        <= '0;
            bytes_seen_reg <= '0;
            length_reg     <= '0;
            high_hold_reg  <= '0;
            name_cnt_reg   <= '0;
            block_cnt_reg  <= '0;
            retry_cnt_reg  <= '0;
        end else if (in_take) begin
            phase_reg      <= phase_next;
            crc_reg        <= crc_next;
            bytes_seen_reg <= bytes_seen_next;
            length_reg     <= length_next;
            high_hold_reg  <= high_hold_next;
            name_cnt_reg   <= name_cnt_next;
            block_cnt_reg  <= block_cnt_next;
            retry_cnt_reg  <= retry_cnt_next;
        end
    end

endmodule

// ===== src/brca_out.sv =====
// Output register stage: holds one result item until the sink takes it.
module brca_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  brca_pkg::res_t in_res,
    output logic           out_valid,
    input  logic           out_ready,
    output brca_pkg::res_t out_res
);
    import brca_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // Take a new item when empty or when the held one leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

// ===== src/block_receive_crc_ack_core.sv =====
// Top level of the block receive core: CRC-checked block reception with ACK/NAK.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  rx_byte
//  m_        out        m_tvalid / m_tready  result item (tdata, tuser)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each link byte's result is registered and shows in the cycle after acceptance.
// A new byte is taken every cycle while the output register is empty or drains.
// The phase, CRC and counters update together on each taken byte through a byte-wide CRC step.
// Reset (aresetn low, synchronous) returns to idle and loads the default codes.
// A stalled sink holds the result and, with it, s_tready.
module block_receive_crc_ack_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // rx_byte
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,
    // reply_kind[1:0], payload_byte[9:2], block_status[11:10],
    // block_number[27:12], retry_number[35:28], block_length[51:36],
    // received_crc[67:52], computed_crc[83:68], zeros[87:84]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [brca_pkg::TDATA_W-1:0]         m_tdata,
    // payload_kind[1:0]
    output logic [1:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [brca_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [brca_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import brca_pkg::*;

    cfg_t cfg;
    res_t res_comb;
    res_t res_out;
    logic in_take;

    assign in_take = s_tvalid && s_tready;

    brca_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    brca_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_take (in_take),
        .rx_byte (s_tdata),
        .res     (res_comb)
    );

    brca_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (res_comb),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res_out)
    );

    // Pack the result item
    assign m_tdata = {4'd0,
                      res_out.computed_crc,
                      res_out.received_crc,
                      res_out.block_length,
                      res_out.retry_number,
                      res_out.block_number,
                      res_out.block_status,
                      res_out.payload_byte,
                      res_out.reply_kind};
    assign m_tuser = res_out.payload_kind;

endmodule
